// ----- rtl/lcis_pkg.sv -----
package lcis_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       enable_out;
    logic [3:0] igniter_lines;
    logic [2:0] reply_code;
    logic [1:0] event_code;
  } out_item_t;

  // one classified request handed from the front to the back
  typedef struct packed {
    logic       is_tick;
    logic [2:0] reply;
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT0,
    PH_WAIT1,
    PH_WAITOFF,
    PH_DONE
  } phase_t;

  localparam logic [2:0] REPLY_NONE   = 3'd0;
  localparam logic [2:0] REPLY_ABORT  = 3'd1;
  localparam logic [2:0] REPLY_TESTBT = 3'd2;
  localparam logic [2:0] REPLY_TESTRF = 3'd3;
  localparam logic [2:0] REPLY_TEN    = 3'd4;
  localparam logic [2:0] REPLY_THREE  = 3'd5;
  localparam logic [2:0] REPLY_ONE    = 3'd6;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_IGN0    = 2'd1;
  localparam logic [1:0] EV_IGN1    = 2'd2;
  localparam logic [1:0] EV_ALL_OFF = 2'd3;

  localparam logic [1:0] CFG_WAIT_TICKS   = 2'd0;
  localparam logic [1:0] CFG_SECOND_TICKS = 2'd1;
  localparam logic [1:0] CFG_OFF_TICKS    = 2'd2;

  localparam logic [7:0] WAIT_TICKS_RST   = 8'd58;
  localparam logic [7:0] SECOND_TICKS_RST = 8'd11;
  localparam logic [7:0] OFF_TICKS_RST    = 8'd20;
  localparam logic [7:0] TICK_MAX         = 8'hFF;

  localparam int WORD_COUNT = 6;
  localparam int WORD_MAX   = 7;

  // words in priority order
  localparam logic [7:0] WORD_TEXT [WORD_COUNT][WORD_MAX] = '{
    '{"T", "E", "S", "T", "B", "T", 8'h00},
    '{"T", "E", "S", "T", "R", "F", 8'h00},
    '{"A", "B", "O", "R", "T", "A", "R"},
    '{"D", "I", "E", "Z", 8'h00, 8'h00, 8'h00},
    '{"T", "R", "E", "S", 8'h00, 8'h00, 8'h00},
    '{"U", "N", "O", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] WORD_LEN [WORD_COUNT] = '{3'd6, 3'd6, 3'd7, 3'd4, 3'd4, 3'd3};
  localparam logic [2:0] WORD_REPLY [WORD_COUNT] = '{
    REPLY_TESTBT, REPLY_TESTRF, REPLY_ABORT, REPLY_TEN, REPLY_THREE, REPLY_ONE
  };

endpackage

// ----- rtl/lcis_fifo.sv -----
module lcis_fifo #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH))
    else $error("fifo count beyond depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (count_r == $past(count_r) + 1'b1))
    else $error("fifo count did not follow a lone write");

  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("fifo pointers differ while empty");

endmodule

// ----- rtl/lcis_front.sv -----
module lcis_front #(
  parameter int MAX_WORD_LEN = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  lcis_pkg::in_item_t item,
  output lcis_pkg::op_t     op
);

  import lcis_pkg::*;

  localparam int PW = $clog2(MAX_WORD_LEN + 1);

  logic [PW-1:0]         pos_r, pos_nxt;
  logic [WORD_COUNT-1:0] alive_r, alive_nxt;
  logic                  started_r, started_nxt;
  logic [2:0]            reply;

  // first live word whose letters were all seen wins
  always_comb begin
    reply = REPLY_NONE;
    for (int w = WORD_COUNT - 1; w >= 0; w--) begin
      if (alive_r[w] && (pos_r >= PW'(WORD_LEN[w]))) begin
        reply = WORD_REPLY[w];
      end
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    alive_nxt   = alive_r;
    started_nxt = started_r;
    op.is_tick  = item.cmd;
    op.reply    = REPLY_NONE;
    if (accept && !item.cmd && !started_r) begin
      if (item.rx_byte == 8'h00) begin
        op.reply  = reply;
        pos_nxt   = '0;
        alive_nxt = '1;
        if (reply == REPLY_ONE) begin
          started_nxt = 1'b1;
        end
      end else if (pos_r < PW'(MAX_WORD_LEN)) begin
        for (int w = 0; w < WORD_COUNT; w++) begin
          if ((pos_r < PW'(WORD_LEN[w])) &&
              (WORD_TEXT[w][pos_r[2:0]] != item.rx_byte)) begin
            alive_nxt[w] = 1'b0;
          end
        end
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      alive_r   <= '1;
      started_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      alive_r   <= alive_nxt;
      started_r <= started_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (pos_r == '0 && alive_r == '1))
    else $error("word matcher moved after start");

  assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(MAX_WORD_LEN))
    else $error("character position past limit");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(started_r) |-> $past(accept && op.reply == REPLY_ONE))
    else $error("start without one acknowledged");

endmodule

// ----- rtl/lcis_back.sv -----
module lcis_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                op_valid,
  input  lcis_pkg::op_t       op,
  output lcis_pkg::out_item_t res
);

  import lcis_pkg::*;

  logic [7:0] wait_ticks_r, second_ticks_r, off_ticks_r;
  phase_t     phase_r, phase_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic       enable_r, enable_nxt;
  logic [1:0] ign_r, ign_nxt;
  logic [1:0] event_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_ticks_r   <= WAIT_TICKS_RST;
      second_ticks_r <= SECOND_TICKS_RST;
      off_ticks_r    <= OFF_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WAIT_TICKS:   wait_ticks_r   <= cfg_data;
        CFG_SECOND_TICKS: second_ticks_r <= cfg_data;
        CFG_OFF_TICKS:    off_ticks_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    enable_nxt = enable_r;
    ign_nxt    = ign_r;
    event_code = EV_NONE;
    if (op.is_tick) begin
      if (phase_r != PH_IDLE) begin
        tick_nxt = (tick_r != TICK_MAX) ? tick_r + 1'b1 : tick_r;
        case (phase_r)
          PH_WAIT0: begin
            if (tick_r >= wait_ticks_r) begin
              ign_nxt[0] = 1'b1;
              tick_nxt   = 8'd1;
              phase_nxt  = PH_WAIT1;
              event_code = EV_IGN0;
            end
          end
          PH_WAIT1: begin
            if (tick_r >= second_ticks_r) begin
              ign_nxt[1] = 1'b1;
              phase_nxt  = PH_WAITOFF;
              event_code = EV_IGN1;
            end
          end
          PH_WAITOFF: begin
            if (tick_r >= off_ticks_r) begin
              ign_nxt    = 2'b00;
              phase_nxt  = PH_DONE;
              event_code = EV_ALL_OFF;
            end
          end
          default: ;
        endcase
      end
    end else begin
      case (op.reply)
        REPLY_ABORT: begin
          enable_nxt = 1'b0;
          ign_nxt    = 2'b00;
        end
        REPLY_THREE: enable_nxt = 1'b1;
        REPLY_ONE:   phase_nxt  = PH_WAIT0;
        default: ;
      endcase
    end
    res.enable_out    = enable_nxt;
    res.igniter_lines = {2'b00, ign_nxt};
    res.reply_code    = op.is_tick ? REPLY_NONE : op.reply;
    res.event_code    = event_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      tick_r   <= '0;
      enable_r <= 1'b0;
      ign_r    <= 2'b00;
    end else if (op_valid) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      enable_r <= enable_nxt;
      ign_r    <= ign_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    ign_r[1] |-> (phase_r == PH_WAITOFF))
    else $error("igniter one on outside its phase");

  assert property (@(posedge clk) disable iff (!rst_n)
    ign_r[0] |-> (phase_r == PH_WAIT1 || phase_r == PH_WAITOFF))
    else $error("igniter zero on outside its phases");

  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (tick_r == '0))
    else $error("ticks counted before start");

endmodule

// ----- rtl/launch_command_ignition_sequencer_core.sv -----
// Launch command and ignition sequencer. Each request is either a command-link
// byte or a timer tick and yields exactly one result, in order. Bytes are
// matched against the command words in the front stage; ticks drive the
// igniter sequence in the back stage once UNO has been acknowledged. A
// request can be pushed every cycle. It is registered in the command queue and
// its result in the result queue. The sustained rate of one request per cycle
// is set by the back stage, which updates the sequence state once per cycle.
// Both sides stall independently through the two-entry command and result
// queues. Configuration writes take effect on the next cycle and are meant to
// happen only while both queues are empty.
module launch_command_ignition_sequencer_core #(
  parameter int MAX_WORD_LEN = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  lcis_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output lcis_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  import lcis_pkg::*;

  localparam int OP_W  = $bits(op_t);
  localparam int RES_W = $bits(out_item_t);

  op_t        front_op, back_op;
  out_item_t  back_res;
  logic       accept;
  logic       q_empty, res_full, back_go;
  logic [OP_W-1:0]  q_rd;
  logic [RES_W-1:0] res_rd;

  assign accept  = push && !full;
  assign back_go = !q_empty && !res_full;
  assign back_op = op_t'(q_rd);
  assign out_data = out_item_t'(res_rd);

  lcis_front #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .op     (front_op)
  );

  lcis_fifo #(
    .WIDTH(OP_W),
    .DEPTH(2)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (front_op),
    .full    (full),
    .rd_en   (back_go),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  lcis_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op_valid  (back_go),
    .op        (back_op),
    .res       (back_res)
  );

  lcis_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (back_go),
    .wr_data (back_res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

endmodule
